// ===== src/qau_pkg.sv =====
// ----------------------------------------------------------------------------
// qau_pkg
// shared types, constants and fixed point helpers of the quaternion unit
// ----------------------------------------------------------------------------
`default_nettype none

package qau_pkg;

   localparam int DW           = 32;            // component width
   localparam int FRAC_BITS    = 16;            // fraction bits of a component
   localparam int CORDIC_STEPS = 16;            // cordic micro-rotations
   localparam int PW           = 2 * DW;        // full product
   localparam int SW           = PW + 2;        // sum of four products
   localparam int CW           = 54;            // cordic x/y datapath
   localparam int ZW           = 20;            // cordic angle accumulator
   localparam int ISQRT_STEPS  = DW;            // one root bit per step
   localparam int RW           = DW + 1;        // root, up to 2^32
   localparam int QW           = FRAC_BITS + 1; // normalized magnitude
   localparam int DV           = RW + QW - 1;   // divider remainder
   localparam int ASH          = 30 - FRAC_BITS;

   localparam int QMUL_LAT = 4;
   localparam int YAW_LAT  = CORDIC_STEPS + 2;
   localparam int NORM_LAT = ISQRT_STEPS + QW + 4;

   typedef enum logic [2:0] {
      MODE_MUL  = 3'd0,
      MODE_CONJ = 3'd1,
      MODE_ROT  = 3'd2,
      MODE_NORM = 3'd3,
      MODE_YAW  = 3'd4
   } mode_type;

   typedef logic signed [DW-1:0] comp_type;
   typedef logic signed [PW-1:0] prod_type;
   typedef logic signed [SW-1:0] acc_type;

   typedef struct packed {
      logic signed [DW-1:0] val;
      logic                 flag;
   } sat_type;

   // hamilton product: operand select and sign of each term
   localparam logic [1:0] BSEL [4][4] = '{
      '{2'd0, 2'd1, 2'd2, 2'd3},
      '{2'd1, 2'd0, 2'd3, 2'd2},
      '{2'd2, 2'd3, 2'd0, 2'd1},
      '{2'd3, 2'd2, 2'd1, 2'd0}
   };
   localparam logic NEG [4][4] = '{
      '{1'b0, 1'b1, 1'b1, 1'b1},
      '{1'b0, 1'b0, 1'b0, 1'b1},
      '{1'b0, 1'b1, 1'b0, 1'b0},
      '{1'b0, 1'b0, 1'b1, 1'b0}
   };

   localparam acc_type RND_HALF =
      {{(SW-FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS-1){1'b0}}};

   localparam logic [31:0] HALF_PI_Q30 = 32'h6487ED51;
   localparam logic [32:0] HP_WIDE =
      ({1'b0, HALF_PI_Q30} + (33'd1 << (ASH - 1))) >> ASH;
   localparam logic signed [ZW-1:0] HP = HP_WIDE[ZW-1:0];

   // round to nearest, ties up, then drop the fraction
   function automatic acc_type rnd_frac(input acc_type v);
      return (v + RND_HALF) >>> FRAC_BITS;
   endfunction

   // clamp to the component range
   function automatic sat_type sat_comp(input acc_type v);
      sat_type r;
      if (v[SW-1:DW-1] == '0 || v[SW-1:DW-1] == '1) begin
         r.val  = v[DW-1:0];
         r.flag = 1'b0;
      end else begin
         r.flag = 1'b1;
         r.val  = v[SW-1] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
      end
      return r;
   endfunction

   // arctangent of 2^-i in q30
   function automatic logic [31:0] atan_q30(input int i);
      logic [31:0] r;
      case (i)
         0:  r = 32'h3243F6A8;
         1:  r = 32'h1DAC6705;
         2:  r = 32'h0FADBAFC;
         3:  r = 32'h07F56EA6;
         4:  r = 32'h03FEAB76;
         5:  r = 32'h01FFD55B;
         6:  r = 32'h00FFFAAA;
         7:  r = 32'h007FFF55;
         8:  r = 32'h003FFFEA;
         9:  r = 32'h001FFFFD;
         10: r = 32'h000FFFFF;
         11: r = 32'h0007FFFF;
         12: r = 32'h0003FFFF;
         13: r = 32'h0001FFFF;
         14: r = 32'h0000FFFF;
         15: r = 32'h00007FFF;
         16: r = 32'h00003FFF;
         17: r = 32'h00001FFF;
         18: r = 32'h00000FFF;
         19: r = 32'h000007FF;
         20: r = 32'h000003FF;
         21: r = 32'h000001FF;
         22: r = 32'h000000FF;
         23: r = 32'h0000007F;
         24: r = 32'h0000003F;
         25: r = 32'h0000001F;
         26: r = 32'h0000000F;
         27: r = 32'h00000008;
         28: r = 32'h00000004;
         29: r = 32'h00000002;
         30: r = 32'h00000001;
         default: r = 32'h00000000;
      endcase
      return r;
   endfunction

   function automatic logic signed [ZW-1:0] atan_frac(input int i);
      logic [32:0] w;
      w = ({1'b0, atan_q30(i)} + (33'd1 << (ASH - 1))) >> ASH;
      return w[ZW-1:0];
   endfunction

endpackage

`default_nettype wire

// ===== src/qau_delay.sv =====
// ----------------------------------------------------------------------------
// qau_delay
// enabled shift register that aligns a short path to the longest one
// ----------------------------------------------------------------------------
`default_nettype none

module qau_delay #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 1
) (
   input  logic             clock,
   input  logic             en,
   input  logic [WIDTH-1:0] d_i,
   output logic [WIDTH-1:0] d_o
);

   logic [WIDTH-1:0] sr_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (en) begin
         sr_ff[0] <= d_i;
         for (int i = 1; i < DEPTH; i++) begin
            sr_ff[i] <= sr_ff[i-1];
         end
      end
   end

   assign d_o = sr_ff[DEPTH-1];

endmodule

`default_nettype wire

// ===== src/qau_qmul.sv =====
// ----------------------------------------------------------------------------
// qau_qmul
// two chained hamilton products: multiply, conjugate and vector rotation
// ----------------------------------------------------------------------------
`default_nettype none

module qau_qmul
   import qau_pkg::*;
(
   input  logic     clock,
   input  logic     en,
   input  mode_type mode_i,
   input  comp_type a_i [4],
   input  comp_type b_i [4],
   output comp_type res_o [4],
   output logic     sat_o
);

   prod_type p1_ff [4][4];
   prod_type p1_in [4][4];
   comp_type c1_ff [4];
   comp_type c1_in [4];
   logic     csat1_ff, csat1_in;
   mode_type mode1_ff;

   comp_type t2_ff [4];
   comp_type t2_in [4];
   logic     tsat2_ff, tsat2_in;
   comp_type c2_ff [4];
   logic     csat2_ff;
   mode_type mode2_ff;

   prod_type p3_ff [4][4];
   prod_type p3_in [4][4];
   comp_type t3_ff [4];
   comp_type c3_ff [4];
   logic     tsat3_ff, csat3_ff;
   mode_type mode3_ff;

   comp_type res_ff [4];
   comp_type res_in [4];
   logic     sat_ff, sat_in;

   function automatic sat_type dot4(input prod_type p [4], input int c);
      acc_type acc;
      acc = '0;
      for (int k = 0; k < 4; k++) begin
         if (NEG[c][k]) acc = acc - SW'(p[k]);
         else           acc = acc + SW'(p[k]);
      end
      return sat_comp(rnd_frac(acc));
   endfunction

   // stage 1: first product array, conjugate of a
   always_comb begin
      comp_type            bb [4];
      logic signed [DW:0]  ax;
      sat_type             cs;
      csat1_in = 1'b0;
      c1_in[0] = a_i[0];
      for (int k = 0; k < 4; k++) begin
         bb[k] = (mode_i == MODE_ROT && k == 0) ? comp_type'(0) : b_i[k];
      end
      for (int k = 1; k < 4; k++) begin
         ax       = {a_i[k][DW-1], a_i[k]};
         cs       = sat_comp(SW'(-ax));
         c1_in[k] = cs.val;
         csat1_in = csat1_in | cs.flag;
      end
      for (int c = 0; c < 4; c++) begin
         for (int k = 0; k < 4; k++) begin
            p1_in[c][k] = a_i[k] * bb[BSEL[c][k]];
         end
      end
   end

   // stage 2: round and clamp the first product
   always_comb begin
      sat_type ts;
      tsat2_in = 1'b0;
      for (int c = 0; c < 4; c++) begin
         ts       = dot4(p1_ff[c], c);
         t2_in[c] = ts.val;
         tsat2_in = tsat2_in | ts.flag;
      end
   end

   // stage 3: second product array, t * conj(a)
   always_comb begin
      for (int c = 0; c < 4; c++) begin
         for (int k = 0; k < 4; k++) begin
            p3_in[c][k] = t2_ff[k] * c2_ff[BSEL[c][k]];
         end
      end
   end

   // stage 4: round, clamp and pick the result of the mode
   always_comb begin
      sat_type os [4];
      logic    osat;
      osat = 1'b0;
      for (int c = 0; c < 4; c++) begin
         os[c] = dot4(p3_ff[c], c);
         osat  = osat | os[c].flag;
      end
      for (int k = 0; k < 4; k++) res_in[k] = '0;
      sat_in = 1'b0;
      case (mode3_ff)
         MODE_MUL: begin
            res_in = t3_ff;
            sat_in = tsat3_ff;
         end
         MODE_CONJ: begin
            res_in = c3_ff;
            sat_in = csat3_ff;
         end
         MODE_ROT: begin
            for (int k = 1; k < 4; k++) res_in[k] = os[k].val;
            sat_in = csat3_ff | tsat3_ff | osat;
         end
         default: begin
            sat_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p1_ff    <= p1_in;
         c1_ff    <= c1_in;
         csat1_ff <= csat1_in;
         mode1_ff <= mode_i;

         t2_ff    <= t2_in;
         tsat2_ff <= tsat2_in;
         c2_ff    <= c1_ff;
         csat2_ff <= csat1_ff;
         mode2_ff <= mode1_ff;

         p3_ff    <= p3_in;
         t3_ff    <= t2_ff;
         c3_ff    <= c2_ff;
         tsat3_ff <= tsat2_ff;
         csat3_ff <= csat2_ff;
         mode3_ff <= mode2_ff;

         res_ff   <= res_in;
         sat_ff   <= sat_in;
      end
   end

   assign res_o = res_ff;
   assign sat_o = sat_ff;

endmodule

`default_nettype wire

// ===== src/qau_yaw.sv =====
// ----------------------------------------------------------------------------
// qau_yaw
// yaw angle of a quaternion through a pipelined vectoring cordic
// ----------------------------------------------------------------------------
`default_nettype none

module qau_yaw
   import qau_pkg::*;
(
   input  logic     clock,
   input  logic     en,
   input  comp_type a_i [4],
   output comp_type ang_o
);

   typedef logic signed [CW-1:0] cd_type;
   typedef logic signed [ZW-1:0] ang_type;

   prod_type wz_ff, xy_ff, yy_ff, zz_ff;

   cd_type  x_ff  [CORDIC_STEPS+1];
   cd_type  x_in  [CORDIC_STEPS+1];
   cd_type  y_ff  [CORDIC_STEPS+1];
   cd_type  y_in  [CORDIC_STEPS+1];
   ang_type z_ff  [CORDIC_STEPS+1];
   ang_type z_in  [CORDIC_STEPS+1];
   logic    zr_ff [CORDIC_STEPS+1];
   logic    zr_in [CORDIC_STEPS+1];

   always_comb begin
      acc_type sy, sx;
      cd_type  xv, yv;
      // arguments of atan2: 2(wz+xy) and 1-2(yy+zz)
      sy = rnd_frac(SW'(wz_ff) + SW'(xy_ff));
      sx = rnd_frac(SW'(yy_ff) + SW'(zz_ff));
      yv = CW'(sy) <<< 1;
      xv = (CW'(1) <<< FRAC_BITS) - (CW'(sx) <<< 1);
      x_in[0]  = xv;
      y_in[0]  = yv;
      z_in[0]  = '0;
      zr_in[0] = (xv == 0) && (yv == 0);
      // left half plane: turn by a quarter first
      if (xv < 0) begin
         if (yv >= 0) begin
            x_in[0] = yv;
            y_in[0] = -xv;
            z_in[0] = HP;
         end else begin
            x_in[0] = -yv;
            y_in[0] = xv;
            z_in[0] = -HP;
         end
      end
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         if (y_ff[i] > 0) begin
            x_in[i+1] = x_ff[i] + (y_ff[i] >>> i);
            y_in[i+1] = y_ff[i] - (x_ff[i] >>> i);
            z_in[i+1] = z_ff[i] + atan_frac(i);
         end else begin
            x_in[i+1] = x_ff[i] - (y_ff[i] >>> i);
            y_in[i+1] = y_ff[i] + (x_ff[i] >>> i);
            z_in[i+1] = z_ff[i] - atan_frac(i);
         end
         zr_in[i+1] = zr_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         wz_ff <= a_i[0] * a_i[3];
         xy_ff <= a_i[1] * a_i[2];
         yy_ff <= a_i[2] * a_i[2];
         zz_ff <= a_i[3] * a_i[3];
         x_ff  <= x_in;
         y_ff  <= y_in;
         z_ff  <= z_in;
         zr_ff <= zr_in;
      end
   end

   assign ang_o = zr_ff[CORDIC_STEPS] ? comp_type'(0) : DW'(z_ff[CORDIC_STEPS]);

endmodule

`default_nettype wire

// ===== src/qau_norm.sv =====
// ----------------------------------------------------------------------------
// qau_norm
// normalization: sum of squares, pipelined integer root, pipelined divide
// ----------------------------------------------------------------------------
`default_nettype none

module qau_norm
   import qau_pkg::*;
(
   input  logic     clock,
   input  logic     en,
   input  comp_type a_i [4],
   output comp_type res_o [4],
   output logic     sat_o,
   output logic     zero_o
);

   localparam int NS = ISQRT_STEPS;

   logic [PW-1:0] sq1_ff [4];
   logic [DW-1:0] mg1_ff [4];
   logic          ng1_ff [4];

   // root stages
   logic [PW-1:0] rm_ff [NS+1];
   logic [PW-1:0] rm_in [NS+1];
   logic [PW-1:0] rt_ff [NS+1];
   logic [PW-1:0] rt_in [NS+1];
   logic [DW-1:0] mg_ff [NS+1][4];
   logic          ng_ff [NS+1][4];
   logic          cy_ff [NS+1];
   logic          zr_ff [NS+1];
   logic [PW+1:0] sm;

   // divide stages
   logic [RW-1:0] dr_ff [QW+1];
   logic [RW-1:0] root;
   logic [DV-1:0] dm_ff [QW+1][4];
   logic [DV-1:0] dm_in [QW+1][4];
   logic [QW-1:0] q_ff  [QW+1][4];
   logic [QW-1:0] q_in  [QW+1][4];
   logic [DW-1:0] dmg_ff [QW+1][4];
   logic          dng_ff [QW+1][4];
   logic          dzr_ff [QW+1];

   comp_type res_ff [4];
   comp_type res_in [4];
   logic     sat_ff, sat_in;
   logic     zn_ff;

   always_comb begin
      logic [PW-1:0] bitv, cmp;
      logic [DV-1:0] dv;
      sm = {2'b00, sq1_ff[0]} + {2'b00, sq1_ff[1]} + {2'b00, sq1_ff[2]} + {2'b00, sq1_ff[3]};
      rm_in[0] = sm[PW-1:0];
      rt_in[0] = '0;
      // one root bit per stage
      for (int j = 0; j < NS; j++) begin
         bitv = PW'(1) << (PW - 2 - 2 * j);
         cmp  = rt_ff[j] + bitv;
         if (rm_ff[j] >= cmp) begin
            rm_in[j+1] = rm_ff[j] - cmp;
            rt_in[j+1] = (rt_ff[j] >> 1) + bitv;
         end else begin
            rm_in[j+1] = rm_ff[j];
            rt_in[j+1] = rt_ff[j] >> 1;
         end
      end
      // a sum that wrapped past 64 bits has root 2^32
      root = cy_ff[NS] ? (RW'(1) << DW) : rt_ff[NS][RW-1:0];
      for (int k = 0; k < 4; k++) begin
         dm_in[0][k] = (DV'(mg_ff[NS][k]) << FRAC_BITS) + DV'(root >> 1);
         q_in[0][k]  = '0;
      end
      // restoring divide, one quotient bit per stage
      for (int j = 0; j < QW; j++) begin
         dv = DV'(dr_ff[j]) << (QW - 1 - j);
         for (int k = 0; k < 4; k++) begin
            if (dm_ff[j][k] >= dv) begin
               dm_in[j+1][k] = dm_ff[j][k] - dv;
               q_in[j+1][k]  = {q_ff[j][k][QW-2:0], 1'b1};
            end else begin
               dm_in[j+1][k] = dm_ff[j][k];
               q_in[j+1][k]  = {q_ff[j][k][QW-2:0], 1'b0};
            end
         end
      end
   end

   always_comb begin
      acc_type sv;
      sat_type rs;
      sat_in = 1'b0;
      for (int k = 0; k < 4; k++) begin
         sv = SW'({1'b0, q_ff[QW][k]});
         if (dng_ff[QW][k]) sv = -sv;
         rs = sat_comp(sv);
         if (dzr_ff[QW]) begin
            // zero norm: a comes back unchanged
            res_in[k] = dng_ff[QW][k] ? comp_type'(-dmg_ff[QW][k]) : comp_type'(dmg_ff[QW][k]);
         end else begin
            res_in[k] = rs.val;
            sat_in    = sat_in | rs.flag;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 4; k++) begin
            mg1_ff[k] <= a_i[k][DW-1] ? DW'(-a_i[k]) : a_i[k];
            sq1_ff[k] <= (a_i[k][DW-1] ? DW'(-a_i[k]) : a_i[k])
                       * (a_i[k][DW-1] ? DW'(-a_i[k]) : a_i[k]);
            ng1_ff[k] <= a_i[k][DW-1];
         end
         rm_ff    <= rm_in;
         rt_ff    <= rt_in;
         mg_ff[0] <= mg1_ff;
         ng_ff[0] <= ng1_ff;
         cy_ff[0] <= |sm[PW+1:PW];
         zr_ff[0] <= (sm == '0);
         for (int j = 0; j < NS; j++) begin
            mg_ff[j+1] <= mg_ff[j];
            ng_ff[j+1] <= ng_ff[j];
            cy_ff[j+1] <= cy_ff[j];
            zr_ff[j+1] <= zr_ff[j];
         end
         dm_ff     <= dm_in;
         q_ff      <= q_in;
         dr_ff[0]  <= root;
         dmg_ff[0] <= mg_ff[NS];
         dng_ff[0] <= ng_ff[NS];
         dzr_ff[0] <= zr_ff[NS];
         for (int j = 0; j < QW; j++) begin
            dr_ff[j+1]  <= dr_ff[j];
            dmg_ff[j+1] <= dmg_ff[j];
            dng_ff[j+1] <= dng_ff[j];
            dzr_ff[j+1] <= dzr_ff[j];
         end
         res_ff <= res_in;
         sat_ff <= sat_in;
         zn_ff  <= dzr_ff[QW];
      end
   end

   assign res_o  = res_ff;
   assign sat_o  = sat_ff;
   assign zero_o = zn_ff;

endmodule

`default_nettype wire

// ===== src/quaternion_arithmetic_unit_core.sv =====
// ----------------------------------------------------------------------------
// quaternion_arithmetic_unit_core
// throughput: one transaction per cycle while the skid register is empty, at
//    the same depth to rsp_tvalid in all modes; the normalize root and divide chain
//    (one bit per stage) sets the pipeline depth, every other path is padded
// reset: synchronous, clears stage valid bits, output and skid valids only
// ----------------------------------------------------------------------------
`default_nettype none

module quaternion_arithmetic_unit_core
   import qau_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   // input transaction
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [255:0] req_tdata,  // qa_w, qa_x, qa_y, qa_z, qb_w, qb_x, qb_y, qb_z
   input  logic [2:0]   req_tuser,  // mode
   // result transaction
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [127:0] rsp_tdata,  // res_w, res_x, res_y, res_z
   output logic [1:0]   rsp_tuser   // saturated, zero_norm
);

   localparam int QM_PAD  = NORM_LAT - QMUL_LAT;
   localparam int YAW_PAD = NORM_LAT - YAW_LAT;
   localparam int QM_W    = 4 * DW + 1;
   localparam int OUT_W   = 4 * DW + 2;

   // pipeline advance: the whole datapath moves unless the skid stage is full
   logic adv;
   logic accept;

   comp_type qa [4];
   comp_type qb [4];

   // valid bit of every pipeline stage
   logic [NORM_LAT-1:0] vld_ff;

   // per-unit results
   comp_type          qm_res [4];
   logic              qm_sat;
   logic [QM_W-1:0]   qm_dly;
   comp_type          yaw_ang;
   logic [DW-1:0]     yaw_dly;
   comp_type          nm_res [4];
   logic              nm_sat;
   logic              nm_zn;
   logic [2:0]        mode_dly;

   logic [OUT_W-1:0]  last_res;
   logic              push;

   // output register and skid register
   logic              out_vld_ff, out_vld_in;
   logic [OUT_W-1:0]  out_ff, out_in;
   logic              skid_vld_ff, skid_vld_in;
   logic [OUT_W-1:0]  skid_ff, skid_in;

   assign adv        = !skid_vld_ff;
   assign req_tready = adv;
   assign accept     = req_tvalid && req_tready;

   // unpack the operands, first field in the low bits
   always_comb begin
      for (int k = 0; k < 4; k++) begin
         qa[k] = req_tdata[k*DW +: DW];
         qb[k] = req_tdata[(4+k)*DW +: DW];
      end
   end

   qau_qmul u_qmul (
      .clock  (clock),
      .en     (adv),
      .mode_i (mode_type'(req_tuser)),
      .a_i    (qa),
      .b_i    (qb),
      .res_o  (qm_res),
      .sat_o  (qm_sat)
   );

   qau_yaw u_yaw (
      .clock (clock),
      .en    (adv),
      .a_i   (qa),
      .ang_o (yaw_ang)
   );

   qau_norm u_norm (
      .clock  (clock),
      .en     (adv),
      .a_i    (qa),
      .res_o  (nm_res),
      .sat_o  (nm_sat),
      .zero_o (nm_zn)
   );

   // line the short paths up with the normalize path
   qau_delay #(.WIDTH(QM_W), .DEPTH(QM_PAD)) u_qm_dly (
      .clock (clock),
      .en    (adv),
      .d_i   ({qm_sat, qm_res[3], qm_res[2], qm_res[1], qm_res[0]}),
      .d_o   (qm_dly)
   );

   qau_delay #(.WIDTH(DW), .DEPTH(YAW_PAD)) u_yaw_dly (
      .clock (clock),
      .en    (adv),
      .d_i   (yaw_ang),
      .d_o   (yaw_dly)
   );

   qau_delay #(.WIDTH(3), .DEPTH(NORM_LAT)) u_mode_dly (
      .clock (clock),
      .en    (adv),
      .d_i   (req_tuser),
      .d_o   (mode_dly)
   );

   // pick the result of the item's mode; unknown modes give all zeros
   always_comb begin
      last_res = '0;
      case (mode_type'(mode_dly))
         MODE_MUL, MODE_CONJ, MODE_ROT: begin
            last_res = {1'b0, qm_dly};
         end
         MODE_NORM: begin
            last_res = {nm_zn, nm_sat, nm_res[3], nm_res[2], nm_res[1], nm_res[0]};
         end
         MODE_YAW: begin
            last_res = {2'b00, {(3*DW){1'b0}}, yaw_dly};
         end
         default: begin
            last_res = '0;
         end
      endcase
   end

   assign push = adv && vld_ff[NORM_LAT-1];

   // output register with a one-entry skid behind it
   always_comb begin
      out_vld_in  = out_vld_ff;
      out_in      = out_ff;
      skid_vld_in = skid_vld_ff;
      skid_in     = skid_ff;
      if (!out_vld_ff || rsp_tready) begin
         if (skid_vld_ff) begin
            out_in      = skid_ff;
            out_vld_in  = 1'b1;
            skid_vld_in = 1'b0;
         end else begin
            out_in      = last_res;
            out_vld_in  = push;
         end
      end else if (push) begin
         skid_in     = last_res;
         skid_vld_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff      <= '0;
         out_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else begin
         if (adv) begin
            vld_ff <= {vld_ff[NORM_LAT-2:0], accept};
         end
         out_vld_ff  <= out_vld_in;
         skid_vld_ff <= skid_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = out_ff[4*DW-1:0];
   assign rsp_tuser  = out_ff[OUT_W-1:4*DW];

`ifndef NO_ASSERTIONS
   // the skid only fills behind a waiting output
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_vld_ff |-> out_vld_ff)
      else $error("skid holds a result while the output register is empty");

   // a stalled last stage keeps its item
   a_last_stage_holds: assert property (@(posedge clock) disable iff (reset)
      vld_ff[NORM_LAT-1] && !adv |=> vld_ff[NORM_LAT-1])
      else $error("item dropped from the last stage during a stall");

   // the zero norm path passes a through and never clamps
   a_zero_norm_no_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> !rsp_tuser[0])
      else $error("zero norm result flagged as saturated");
`endif

endmodule

`default_nettype wire

// ===== verif/quaternion_arithmetic_unit_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quaternion_arithmetic_unit_core_tb
// self-checking bench: drives multiply, conjugate, rotate, normalize, yaw and
// undefined-mode transactions with random idling on both sides, and checks
// every result against a bit-exact fixed point predictor
// ----------------------------------------------------------------------------
`default_nettype none

module quaternion_arithmetic_unit_core_tb;
   import qau_pkg::*;

   localparam int  N_RANDOM    = 1100;
   localparam int  DRAIN       = 120;     // leave margin after the last result
   localparam longint LIMIT    = 400000;

   typedef struct {
      logic [31:0] w, x, y, z;
      bit          sat;
      bit          zn;
   } quat_result_type;

   // predicts each result and holds the ones still in flight
   class quat_scoreboard_type;
      quat_result_type pending[$];
      int           errors;
      int           checked;
      int           sel_tab[4][4] = '{'{0,1,2,3}, '{1,0,3,2}, '{2,3,0,1}, '{3,2,1,0}};
      bit           neg_tab[4][4] = '{'{0,1,1,1}, '{0,0,0,1}, '{0,1,0,0}, '{0,0,1,0}};

      function longint clamp32(longint v, inout bit f);
         if (v > 64'sd2147483647) begin
            f = 1;
            return 64'sd2147483647;
         end
         if (v < -64'sd2147483648) begin
            f = 1;
            return -64'sd2147483648;
         end
         return v;
      endfunction

      // exact signed sum of four products, rounded half up by FRAC_BITS
      function longint round_sum(longint p[4], longint q[4], bit n[4]);
         logic signed [79:0] acc;
         acc = 0;
         for (int k = 0; k < 4; k++) begin
            if (n[k]) acc = acc - 80'(p[k]) * 80'(q[k]);
            else      acc = acc + 80'(p[k]) * 80'(q[k]);
         end
         acc = (acc + (80'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
         return longint'(acc);
      endfunction

      function void hamilton(longint a[4], longint b[4], output longint r[4], inout bit f);
         longint bb[4];
         bit     nn[4];
         for (int c = 0; c < 4; c++) begin
            for (int k = 0; k < 4; k++) begin
               bb[k] = b[sel_tab[c][k]];
               nn[k] = neg_tab[c][k];
            end
            r[c] = clamp32(round_sum(a, bb, nn), f);
         end
      endfunction

      function longint unsigned floor_root(longint unsigned s);
         longint unsigned res, bit_v;
         res   = 0;
         bit_v = 64'd1 << 62;
         while (bit_v > s) bit_v = bit_v >> 2;
         while (bit_v != 0) begin
            if (s >= res + bit_v) begin
               s   = s - (res + bit_v);
               res = (res >> 1) + bit_v;
            end else begin
               res = res >> 1;
            end
            bit_v = bit_v >> 2;
         end
         return res;
      endfunction

      function longint q30_frac(longint unsigned v);
         return longint'((v + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS));
      endfunction

      function longint yaw_angle(longint a[4]);
         longint p[4], q[4], xv, yv, zv, t, dx, dy, ang;
         bit     n[4];
         logic [31:0] atab[16] = '{32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6,
            32'h03FEAB76, 32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA,
            32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF,
            32'h0000FFFF, 32'h00007FFF};
         n = '{0, 0, 0, 0};
         p = '{a[0], a[1], 0, 0};
         q = '{a[3], a[2], 0, 0};
         yv = 2 * round_sum(p, q, n);
         p = '{a[2], a[3], 0, 0};
         xv = (64'sd1 <<< FRAC_BITS) - 2 * round_sum(p, p, n);
         zv = 0;
         if (xv == 0 && yv == 0) return 0;
         // left half plane: pre-rotate by a quarter turn
         if (xv < 0) begin
            t = xv;
            if (yv >= 0) begin
               xv = yv;
               yv = -t;
               zv = q30_frac(HALF_PI_Q30);
            end else begin
               xv = -yv;
               yv = t;
               zv = -q30_frac(HALF_PI_Q30);
            end
         end
         for (int i = 0; i < CORDIC_STEPS; i++) begin
            dx  = xv >>> i;
            dy  = yv >>> i;
            ang = q30_frac(atab[i]);
            if (yv > 0) begin
               xv = xv + dy;
               yv = yv - dx;
               zv = zv + ang;
            end else begin
               xv = xv - dy;
               yv = yv + dx;
               zv = zv - ang;
            end
         end
         return zv;
      endfunction

      function void note_request(logic [2:0] mode, logic [255:0] data);
         longint a[4], b[4], r[4], v[4], t[4], c[4], o[4];
         longint unsigned mag[4], q;
         logic [65:0] ssum;
         longint unsigned root;
         quat_result_type e;
         bit f, zn;
         f  = 0;
         zn = 0;
         r  = '{0, 0, 0, 0};
         for (int k = 0; k < 4; k++) begin
            a[k] = longint'($signed(data[32*k +: 32]));
            b[k] = longint'($signed(data[128 + 32*k +: 32]));
         end
         case (mode)
            MODE_MUL: hamilton(a, b, r, f);
            MODE_CONJ: begin
               r[0] = clamp32(a[0], f);
               for (int k = 1; k < 4; k++) r[k] = clamp32(-a[k], f);
            end
            MODE_ROT: begin
               v = '{0, b[1], b[2], b[3]};
               c[0] = clamp32(a[0], f);
               for (int k = 1; k < 4; k++) c[k] = clamp32(-a[k], f);
               hamilton(a, v, t, f);
               hamilton(t, c, o, f);
               r = '{0, o[1], o[2], o[3]};
            end
            MODE_NORM: begin
               ssum = 0;
               for (int k = 0; k < 4; k++) begin
                  mag[k] = a[k] < 0 ? longint'(-a[k]) : a[k];
                  ssum   = ssum + 66'(mag[k] * mag[k]);
               end
               if (ssum == 0) begin
                  zn = 1;
                  r  = a;
               end else begin
                  // only four most-negative components overflow 64 bits
                  root = ssum[65:64] != 0 ? 64'd1 << 32 : floor_root(ssum[63:0]);
                  for (int k = 0; k < 4; k++) begin
                     q    = ((mag[k] << FRAC_BITS) + root / 2) / root;
                     r[k] = clamp32(a[k] < 0 ? -longint'(q) : longint'(q), f);
                  end
               end
            end
            MODE_YAW: r[0] = clamp32(yaw_angle(a), f);
            default: ;
         endcase
         e.w   = r[0][31:0];
         e.x   = r[1][31:0];
         e.y   = r[2][31:0];
         e.z   = r[3][31:0];
         e.sat = f;
         e.zn  = zn;
         pending.push_back(e);
      endfunction

      task report(string what, logic [31:0] got, logic [31:0] want);
         errors++;
         $display("mismatch at %0t: %s got %h expected %h", $time, what, got, want);
      endtask

      task check_result(logic [127:0] data, logic [1:0] user);
         quat_result_type e;
         if (pending.size() == 0) begin
            report("unexpected result", data[31:0], 0);
            return;
         end
         e = pending.pop_front();
         checked++;
         if (data[31:0]   !== e.w) report("res_w", data[31:0], e.w);
         if (data[63:32]  !== e.x) report("res_x", data[63:32], e.x);
         if (data[95:64]  !== e.y) report("res_y", data[95:64], e.y);
         if (data[127:96] !== e.z) report("res_z", data[127:96], e.z);
         if (user[0] !== e.sat) report("saturated", 32'(user[0]), 32'(e.sat));
         if (user[1] !== e.zn)  report("zero_norm", 32'(user[1]), 32'(e.zn));
      endtask
   endclass

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [255:0] req_tdata;   // qa_w, qa_x, qa_y, qa_z, qb_w, qb_x, qb_y, qb_z
   logic [2:0]   req_tuser;   // mode
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [127:0] rsp_tdata;   // res_w, res_x, res_y, res_z
   logic [1:0]   rsp_tuser;   // saturated, zero_norm

   quat_scoreboard_type quat_sb;
   longint cycles = 0;
   int     mode_count[8];
   bit     idle_free;         // stretches with no idling on either side

   quaternion_arithmetic_unit_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   // timeout watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (idle_free || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // result side: random backpressure, check each accepted transaction
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_tready <= (idle_free || pick_gap() == 0);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) quat_sb.check_result(rsp_tdata, rsp_tuser);
   end

   task automatic send_request(logic [2:0] mode, logic [31:0] q[8]);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      for (int k = 0; k < 8; k++) req_tdata[32*k +: 32] <= q[k];
      do @(posedge clock); while (!req_tready);
      quat_sb.note_request(req_tuser, req_tdata);
      mode_count[mode]++;
   endtask

   function automatic logic [31:0] rand_comp();
      logic [31:0] picks[7] = '{32'h80000000, 32'h7FFFFFFF, 32'h0, 32'h1, 32'hFFFFFFFF,
                                32'h00010000, 32'hFFFF0000};
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return picks[$urandom_range(0, 6)];
      if (r < 4)  return $urandom;
      return 32'($urandom_range(0, 32'h40000)) - 32'h20000;   // within +-2.0
   endfunction

   task automatic send_uniform(logic [2:0] mode, logic [31:0] av, logic [31:0] bv);
      logic [31:0] q[8];
      for (int k = 0; k < 8; k++) q[k] = k < 4 ? av : bv;
      send_request(mode, q);
   endtask

   initial begin
      logic [31:0] q[8];
      logic [2:0]  m;
      quat_sb    = new();
      idle_free  = 0;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = MODE_MUL;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: field extremes in every mode
      send_uniform(MODE_MUL, 32'h7FFFFFFF, 32'h7FFFFFFF);
      send_uniform(MODE_MUL, 32'h80000000, 32'h7FFFFFFF);
      send_uniform(MODE_MUL, 32'h00010000, 32'hFFFF0000);
      send_uniform(MODE_CONJ, 32'h80000000, 32'h0);
      send_uniform(MODE_CONJ, 32'h7FFFFFFF, 32'h0);
      send_uniform(MODE_ROT, 32'h80000000, 32'h7FFFFFFF);
      q = '{32'h00010000, 0, 0, 0, 32'h1234, 32'h00030000, 32'hFFFE0000, 32'h00008000};
      send_request(MODE_ROT, q);   // identity rotation
      send_uniform(MODE_NORM, 32'h0, 32'h0);                // zero norm
      send_uniform(MODE_NORM, 32'h80000000, 32'h0);         // sum of squares wraps
      send_uniform(MODE_NORM, 32'h7FFFFFFF, 32'h0);
      q = '{32'h00030000, 32'hFFFC0000, 32'h1, 32'h0, 0, 0, 0, 0};
      send_request(MODE_NORM, q);
      q = '{0, 0, 32'h00008000, 32'h00008000, 0, 0, 0, 0};
      send_request(MODE_YAW, q);   // both atan2 arguments zero
      q = '{32'h0000B505, 0, 0, 32'h0000B505, 0, 0, 0, 0};
      send_request(MODE_YAW, q);   // quarter turn
      q = '{32'h00004000, 0, 0, 32'h0000F000, 0, 0, 0, 0};
      send_request(MODE_YAW, q);   // x below zero, y positive
      q = '{32'h00004000, 0, 0, 32'hFFFF1000, 0, 0, 0, 0};
      send_request(MODE_YAW, q);   // x below zero, y negative
      send_uniform(MODE_YAW, 32'h7FFFFFFF, 32'h0);
      send_uniform(MODE_YAW, 32'h80000000, 32'h0);
      send_uniform(3'd5, 32'h12345678, 32'h9ABCDEF0);
      send_uniform(3'd6, 32'hFFFFFFFF, 32'hFFFFFFFF);
      send_uniform(3'd7, 32'h7FFFFFFF, 32'h80000000);

      // hold the sender until the pipeline has drained completely
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (quat_sb.pending.size() != 0) @(posedge clock);

      for (int i = 0; i < N_RANDOM; i++) begin
         if (i % 200 == 100) idle_free = 1;
         if (i % 200 == 160) idle_free = 0;
         m = $urandom_range(0, 9) == 0 ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
         for (int k = 0; k < 8; k++) q[k] = rand_comp();
         send_request(m, q);
      end
      @(negedge clock);
      req_tvalid <= 1'b0;

      while (quat_sb.pending.size() != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);
      if (quat_sb.pending.size() != 0) quat_sb.report("missing results", quat_sb.pending.size(), 0);

      $display("covered %0d results: mul %0d conj %0d rot %0d norm %0d yaw %0d undefined %0d",
               quat_sb.checked, mode_count[0], mode_count[1], mode_count[2], mode_count[3],
               mode_count[4], mode_count[5] + mode_count[6] + mode_count[7]);
      $display("random idling on both ports with stall-free stretches, %0d mismatches",
               quat_sb.errors);
      if (quat_sb.errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire
